// ===== rtl/mbox_pkg.sv =====
// ----------------------------------------------------------------------------
// mbox_pkg
// Shared types and codes for the bounded mailbox FIFO: request kinds,
// result status codes, register indexes and the controller/datapath links.
// ----------------------------------------------------------------------------
package mbox_pkg;

    // fixed field widths
    localparam int CNT_W      = 5;
    localparam int OWNED_W    = 16;
    localparam int TOTAL_W    = 17;
    localparam int STAT_W     = 32;
    localparam int ID_W       = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // entry memory depth, bounded by the width of the waiting count
    localparam int QUEUE_DEPTH = 16;

    localparam logic [OWNED_W-1:0] OWNED_MAX = '1;

    // request kinds
    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_CLOSE   = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_STORED_DROP  = 3'd1,
        ST_REJ_CLOSED   = 3'd2,
        ST_REJ_OVERFLOW = 3'd3,
        ST_FRAME        = 3'd4,
        ST_EMPTY        = 3'd5,
        ST_CLOSED       = 3'd6,
        ST_DONE         = 3'd7
    } status_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLICY   = 1'b1;

    // overflow policy values
    localparam logic POLICY_DROP_OLDEST = 1'b0;
    localparam logic POLICY_REFUSE      = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request beat
        logic read_mem;  // read head entry
        logic exec;      // commit state and load result
    } mbox_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_ready; // result register can take a new beat
    } mbox_sts_t;

endpackage

// ===== rtl/bounded_mailbox_fifo_top.sv =====
// ----------------------------------------------------------------------------
// bounded_mailbox_fifo_top
// Bounded FIFO mailbox with push, pop, release and close requests, a
// drop-oldest or refuse overflow policy and live statistics.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one result beat. A request passes through
// capture at acceptance, a registered read of the head entry from the entry
// memory, and the state update that loads the result. The input is taken
// again the cycle after the result is loaded, so a new request is accepted
// only once the previous one has been committed, and a new request can be
// accepted while the previous result still waits on out_stall; the update of
// that next request waits until the result register is free. The queue holds
// up to 16 entries. Write the capacity and policy registers only while no
// request is in flight.
module bounded_mailbox_fifo_top #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mbox_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbox_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic [PAYLOAD_WIDTH-1:0]             push_payload,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           status,
    output logic [mbox_pkg::ID_W-1:0]            frame_id,
    output logic [PAYLOAD_WIDTH-1:0]             pop_payload,
    output logic [mbox_pkg::CNT_W-1:0]           waiting_count,
    output logic [mbox_pkg::OWNED_W-1:0]         owned_count,
    output logic [mbox_pkg::CNT_W-1:0]           max_waiting_seen,
    output logic [mbox_pkg::TOTAL_W-1:0]         max_owned_seen,
    output logic [mbox_pkg::STAT_W-1:0]          stored_total,
    output logic [mbox_pkg::STAT_W-1:0]          popped_total,
    output logic [mbox_pkg::STAT_W-1:0]          dropped_total,
    output logic [mbox_pkg::STAT_W-1:0]          overflow_rejects,
    output logic [mbox_pkg::STAT_W-1:0]          closed_rejects
);
    import mbox_pkg::*;

    mbox_cmd_t cmd;
    mbox_sts_t sts;

    // request sequencer
    mbox_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queue datapath
    mbox_dp #(
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .push_payload     (push_payload),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame_id         (frame_id),
        .pop_payload      (pop_payload),
        .waiting_count    (waiting_count),
        .owned_count      (owned_count),
        .max_waiting_seen (max_waiting_seen),
        .max_owned_seen   (max_owned_seen),
        .stored_total     (stored_total),
        .popped_total     (popped_total),
        .dropped_total    (dropped_total),
        .overflow_rejects (overflow_rejects),
        .closed_rejects   (closed_rejects)
    );

endmodule

// ===== rtl/mbox_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbox_ctrl
// Request sequencer: accepts a request beat, reads the head entry, then
// commits the update once the result register is free.
// ----------------------------------------------------------------------------
module mbox_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mbox_pkg::mbox_sts_t sts,
    output mbox_pkg::mbox_cmd_t cmd
);
    import mbox_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.read_mem = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_mem = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.out_ready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/mbox_dp.sv =====
// ----------------------------------------------------------------------------
// mbox_dp
// Mailbox datapath: entry memory, queue pointers, ownership and statistics
// counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module mbox_dp #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mbox_pkg::mbox_cmd_t                  cmd,
    output mbox_pkg::mbox_sts_t                  sts,
    input  logic                                 cfg_we,
    input  logic [mbox_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbox_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                           req_type,
    input  logic [PAYLOAD_WIDTH-1:0]             push_payload,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           status,
    output logic [mbox_pkg::ID_W-1:0]            frame_id,
    output logic [PAYLOAD_WIDTH-1:0]             pop_payload,
    output logic [mbox_pkg::CNT_W-1:0]           waiting_count,
    output logic [mbox_pkg::OWNED_W-1:0]         owned_count,
    output logic [mbox_pkg::CNT_W-1:0]           max_waiting_seen,
    output logic [mbox_pkg::TOTAL_W-1:0]         max_owned_seen,
    output logic [mbox_pkg::STAT_W-1:0]          stored_total,
    output logic [mbox_pkg::STAT_W-1:0]          popped_total,
    output logic [mbox_pkg::STAT_W-1:0]          dropped_total,
    output logic [mbox_pkg::STAT_W-1:0]          overflow_rejects,
    output logic [mbox_pkg::STAT_W-1:0]          closed_rejects
);
    import mbox_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W = $clog2(QUEUE_DEPTH + 1) + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(QUEUE_DEPTH);

    // entry memory
    logic [PAYLOAD_WIDTH-1:0] mem_pay [QUEUE_DEPTH];
    logic [ID_W-1:0]          mem_id  [QUEUE_DEPTH];

    // request and read data registers
    req_t                     req_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [PAYLOAD_WIDTH-1:0] rd_pay_reg;
    logic [ID_W-1:0]          rd_id_reg;

    // queue and statistics state
    logic [PTR_W-1:0]   head_reg,     head_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic               closed_reg,   closed_next;
    logic [ID_W-1:0]    next_id_reg,  next_id_next;
    logic [OWNED_W-1:0] owned_reg,    owned_next;
    logic [STAT_W-1:0]  stored_reg,   stored_next;
    logic [STAT_W-1:0]  popped_reg,   popped_next;
    logic [STAT_W-1:0]  dropped_reg,  dropped_next;
    logic [STAT_W-1:0]  ovf_rej_reg,  ovf_rej_next;
    logic [STAT_W-1:0]  cls_rej_reg,  cls_rej_next;
    logic [CNT_W-1:0]   wm_wait_reg,  wm_wait_next;
    logic [TOTAL_W-1:0] wm_total_reg, wm_total_next;

    // configuration
    logic [CNT_W-1:0] cap_reg;
    logic             policy_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    status_t                  st_reg;
    logic [ID_W-1:0]          fid_reg;
    logic [PAYLOAD_WIDTH-1:0] pop_pay_reg;

    // working signals
    logic [CNT_W-1:0]         eff_cap;
    logic                     full;
    logic [PTR_W-1:0]         head_inc;
    logic [PTR_W-1:0]         base_head;
    logic [CNT_W-1:0]         base_count;
    logic [SUM_W-1:0]         slot_sum;
    logic [PTR_W-1:0]         slot;
    logic                     mem_we;
    logic                     wm_upd;
    logic [TOTAL_W-1:0]       total_now;
    status_t                  st_comb;
    logic [ID_W-1:0]          fid_comb;
    logic [PAYLOAD_WIDTH-1:0] pop_pay_comb;

    // effective capacity, clamped to 1..QUEUE_DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(cap_reg) > QUEUE_DEPTH)
        begin
            eff_cap = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full     = (count_reg >= eff_cap);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    // tail slot, after the oldest entry is dropped when full
    assign base_head  = full ? head_inc : head_reg;
    assign base_count = full ? count_reg - 1'b1 : count_reg;
    assign slot_sum   = SUM_W'(base_head) + SUM_W'(base_count);
    assign slot       = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S)
                                              : PTR_W'(slot_sum);

    // request execution
    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        closed_next  = closed_reg;
        next_id_next = next_id_reg;
        owned_next   = owned_reg;
        stored_next  = stored_reg;
        popped_next  = popped_reg;
        dropped_next = dropped_reg;
        ovf_rej_next = ovf_rej_reg;
        cls_rej_next = cls_rej_reg;
        st_comb      = ST_DONE;
        fid_comb     = '0;
        pop_pay_comb = '0;
        mem_we       = 1'b0;
        wm_upd       = 1'b0;
        case (req_reg)
            REQ_PUSH:
            begin
                if (closed_reg)
                begin
                    cls_rej_next = cls_rej_reg + 1'b1;
                    st_comb      = ST_REJ_CLOSED;
                end
                else if (full && (policy_reg == POLICY_REFUSE))
                begin
                    ovf_rej_next = ovf_rej_reg + 1'b1;
                    st_comb      = ST_REJ_OVERFLOW;
                    wm_upd       = 1'b1;
                end
                else
                begin
                    if (full)
                    begin
                        head_next    = head_inc;
                        dropped_next = dropped_reg + 1'b1;
                        st_comb      = ST_STORED_DROP;
                    end
                    else
                    begin
                        st_comb = ST_STORED;
                    end
                    count_next   = base_count + 1'b1;
                    mem_we       = 1'b1;
                    fid_comb     = next_id_reg;
                    next_id_next = next_id_reg + 1'b1;
                    stored_next  = stored_reg + 1'b1;
                    wm_upd       = 1'b1;
                end
            end
            REQ_POP:
            begin
                if (count_reg == '0)
                begin
                    st_comb = closed_reg ? ST_CLOSED : ST_EMPTY;
                end
                else
                begin
                    fid_comb     = rd_id_reg;
                    pop_pay_comb = rd_pay_reg;
                    head_next    = head_inc;
                    count_next   = count_reg - 1'b1;
                    if (owned_reg != OWNED_MAX)
                    begin
                        owned_next = owned_reg + 1'b1;
                    end
                    popped_next = popped_reg + 1'b1;
                    st_comb     = ST_FRAME;
                    wm_upd      = 1'b1;
                end
            end
            REQ_RELEASE:
            begin
                if (owned_reg != '0)
                begin
                    owned_next = owned_reg - 1'b1;
                end
                wm_upd = 1'b1;
            end
            REQ_CLOSE:
            begin
                closed_next = 1'b1;
                wm_upd      = 1'b1;
            end
            default:
            begin
                st_comb = ST_DONE;
            end
        endcase
    end

    // watermarks from the updated state
    assign total_now = TOTAL_W'(count_next) + TOTAL_W'(owned_next);

    always_comb
    begin
        wm_wait_next  = wm_wait_reg;
        wm_total_next = wm_total_reg;
        if (wm_upd && (count_next > wm_wait_reg))
        begin
            wm_wait_next = count_next;
        end
        if (wm_upd && (total_now > wm_total_reg))
        begin
            wm_total_next = total_now;
        end
    end

    // result valid: set on commit, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.out_ready = !out_valid_reg || !out_stall;

    // entry memory write and registered head read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem_pay[slot] <= pay_reg;
            mem_id[slot]  <= next_id_reg;
        end
        if (cmd.read_mem)
        begin
            rd_pay_reg <= mem_pay[head_reg];
            rd_id_reg  <= mem_id[head_reg];
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_t'(req_type);
            pay_reg <= push_payload;
        end
        if (cmd.exec)
        begin
            st_reg      <= st_comb;
            fid_reg     <= fid_comb;
            pop_pay_reg <= pop_pay_comb;
        end
    end

    // control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            next_id_reg   <= ID_W'(1);
            owned_reg     <= '0;
            stored_reg    <= '0;
            popped_reg    <= '0;
            dropped_reg   <= '0;
            ovf_rej_reg   <= '0;
            cls_rej_reg   <= '0;
            wm_wait_reg   <= '0;
            wm_total_reg  <= '0;
            cap_reg       <= CNT_W'(16);
            policy_reg    <= POLICY_DROP_OLDEST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.exec)
            begin
                head_reg     <= head_next;
                count_reg    <= count_next;
                closed_reg   <= closed_next;
                next_id_reg  <= next_id_next;
                owned_reg    <= owned_next;
                stored_reg   <= stored_next;
                popped_reg   <= popped_next;
                dropped_reg  <= dropped_next;
                ovf_rej_reg  <= ovf_rej_next;
                cls_rej_reg  <= cls_rej_next;
                wm_wait_reg  <= wm_wait_next;
                wm_total_reg <= wm_total_next;
            end
            if (cfg_we && (cfg_index == CFG_IDX_CAPACITY))
            begin
                cap_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_IDX_POLICY))
            begin
                policy_reg <= cfg_data[0];
            end
        end
    end

    // result ports; statistics are live and only move on commit
    assign out_valid        = out_valid_reg;
    assign status           = st_reg;
    assign frame_id         = fid_reg;
    assign pop_payload      = pop_pay_reg;
    assign waiting_count    = count_reg;
    assign owned_count      = owned_reg;
    assign max_waiting_seen = wm_wait_reg;
    assign max_owned_seen   = wm_total_reg;
    assign stored_total     = stored_reg;
    assign popped_total     = popped_reg;
    assign dropped_total    = dropped_reg;
    assign overflow_rejects = ovf_rej_reg;
    assign closed_rejects   = cls_rej_reg;

endmodule
